>>> rtl/ovs_pkg.sv
// ----------------------------------------------------------------------------
// ovs_pkg
// Shared widths, register indexes, configuration bundle and controller states
// for the overvoltage stall PI block.
// ----------------------------------------------------------------------------
package ovs_pkg;

	localparam int DATA_W      = 32;
	localparam int UNS_W       = 31;
	localparam int Q_FRAC_BITS = 17;
	localparam int MUL_STEPS   = DATA_W;
	localparam int CNT_W       = $clog2(MUL_STEPS);
	localparam int IDX_W       = 3;
	localparam int SUM_W       = DATA_W + 2;

	localparam logic [IDX_W-1:0] REG_VOLT_THRESHOLD = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_TS_OVER_TI     = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_PROP_GAIN      = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_UPPER_LIMIT    = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_LOWER_LIMIT    = IDX_W'(4);
	localparam logic [IDX_W-1:0] REG_FREQ_MAX       = IDX_W'(5);

	localparam logic signed [DATA_W-1:0] PROP_GAIN_RESET = DATA_W'(1) <<< Q_FRAC_BITS;

	typedef struct packed {
		logic [UNS_W-1:0]         volt_threshold;
		logic [UNS_W-1:0]         ts_over_ti;
		logic signed [DATA_W-1:0] prop_gain;
		logic signed [DATA_W-1:0] upper_limit;
		logic signed [DATA_W-1:0] lower_limit;
		logic [UNS_W-1:0]         freq_max;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL1,
		ST_ADD,
		ST_MUL2,
		ST_CLAMP,
		ST_SUM,
		ST_DONE
	} state_t;

endpackage

>>> rtl/ovs_cfg.sv
// ----------------------------------------------------------------------------
// ovs_cfg
// Configuration register file; writes to unused indexes are ignored.
// ----------------------------------------------------------------------------
module ovs_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [ovs_pkg::IDX_W-1:0] cfg_index,
	input  logic [ovs_pkg::DATA_W-1:0] cfg_data,
	output ovs_pkg::cfg_t             cfg
);
	import ovs_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.volt_threshold <= '0;
			cfg_q.ts_over_ti     <= '0;
			cfg_q.prop_gain      <= PROP_GAIN_RESET;
			cfg_q.upper_limit    <= '0;
			cfg_q.lower_limit    <= '0;
			cfg_q.freq_max       <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VOLT_THRESHOLD: cfg_q.volt_threshold <= cfg_data[UNS_W-1:0];
				REG_TS_OVER_TI:     cfg_q.ts_over_ti     <= cfg_data[UNS_W-1:0];
				REG_PROP_GAIN:      cfg_q.prop_gain      <= $signed(cfg_data);
				REG_UPPER_LIMIT:    cfg_q.upper_limit    <= $signed(cfg_data);
				REG_LOWER_LIMIT:    cfg_q.lower_limit    <= $signed(cfg_data);
				REG_FREQ_MAX:       cfg_q.freq_max       <= cfg_data[UNS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/ovs_mul.sv
// ----------------------------------------------------------------------------
// ovs_mul
// Bit-serial signed Q-format multiplier: one multiplier bit per cycle, then
// the product is taken as a floor shift by the fraction bits, wrapped.
// ----------------------------------------------------------------------------
module ovs_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [ovs_pkg::DATA_W-1:0] a,
	input  logic signed [ovs_pkg::DATA_W-1:0] b,
	output logic                              done,
	output logic signed [ovs_pkg::DATA_W-1:0] prod
);
	import ovs_pkg::*;

	logic                     busy_q;
	logic                     done_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [DATA_W-1:0] a_q;
	logic [DATA_W:0]          hi_q;
	logic [DATA_W-1:0]        lo_q;
	logic                     last;
	logic [DATA_W:0]          a_ext;
	logic [DATA_W:0]          addend;
	logic [DATA_W:0]          sum;
	logic [2*DATA_W-1:0]      full;

	assign last  = (cnt_q == CNT_W'(MUL_STEPS - 1));
	assign a_ext = {a_q[DATA_W-1], a_q};

	// The top multiplier bit carries negative weight.
	always_comb begin
		if (!lo_q[0]) begin
			addend = '0;
		end else if (last) begin
			addend = ~a_ext + (DATA_W+1)'(1);
		end else begin
			addend = a_ext;
		end
		sum = hi_q + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= {sum[DATA_W], sum[DATA_W:1]};
			lo_q <= {sum[0], lo_q[DATA_W-1:1]};
		end
	end

	assign full = {hi_q[DATA_W-1:0], lo_q};
	assign done = done_q;
	assign prod = $signed(full[Q_FRAC_BITS+DATA_W-1:Q_FRAC_BITS]);

endmodule

>>> rtl/overvoltage_stall_pi.sv
// ----------------------------------------------------------------------------
// overvoltage_stall_pi
// An inhibited or idle item goes from the check state straight to the done
// state; an engaged item first passes the first 32-step bit-serial multiply,
// the add state, the second multiply and the clamp and sum states. One item
// is in work at a time: the next is taken only after the last has left for
// the output register, where a finished result waits while the next is taken.
// Reset clears the accumulator, the engaged flag and the output valid, and
// loads the registers with their defaults (gain 1.0, all others zero).
// ----------------------------------------------------------------------------
module overvoltage_stall_pi (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [ovs_pkg::IDX_W-1:0]  cfg_index,
	input  logic [ovs_pkg::DATA_W-1:0] cfg_data,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [63:0]                s_tdata,  // freq_command, bus_voltage, zero pad
	input  logic                       s_tuser,  // inhibit
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [63:0]                m_tdata,  // freq_out, correction
	output logic                       m_tuser   // stall_active
);
	import ovs_pkg::*;

	cfg_t                     cfg;
	state_t                   state_q;
	state_t                   state_next;
	logic                     in_ready;
	logic                     mul_start;
	logic                     mul_sel;
	logic                     out_load;
	logic                     mul_done;
	logic signed [DATA_W-1:0] mul_prod;
	logic signed [DATA_W-1:0] mul_a;
	logic signed [DATA_W-1:0] mul_b;

	logic signed [DATA_W-1:0] cmd_q;
	logic [UNS_W-1:0]         bus_q;
	logic                     inh_q;
	logic [DATA_W-1:0]        mag_q;
	logic                     active_q;
	logic signed [DATA_W-1:0] acc_q;
	logic signed [DATA_W-1:0] corr_q;
	logic [DATA_W-1:0]        freq_q;

	logic                     m_valid_q;
	logic [DATA_W-1:0]        m_freq_q;
	logic [DATA_W-1:0]        m_corr_q;
	logic                     m_act_q;

	logic                     engaged;
	logic signed [DATA_W-1:0] err;
	logic [DATA_W-1:0]        mag;
	logic signed [DATA_W-1:0] acc_sum;
	logic signed [DATA_W-1:0] clamp_hi;
	logic signed [DATA_W-1:0] clamp_res;
	logic signed [SUM_W-1:0]  sum;
	logic [DATA_W-1:0]        out_mag;
	logic                     release_now;

	ovs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ovs_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	always_comb begin
		engaged = !inh_q && ((bus_q >= cfg.volt_threshold) || active_q);
		err     = $signed({1'b0, bus_q}) - $signed({1'b0, cfg.volt_threshold});
		mag     = cmd_q[DATA_W-1] ? (~cmd_q + DATA_W'(1)) : cmd_q;
		acc_sum = acc_q + mul_prod;
		mul_a   = mul_sel ? acc_sum : err;
		mul_b   = mul_sel ? cfg.prop_gain : $signed({1'b0, cfg.ts_over_ti});

		clamp_hi  = (cfg.upper_limit <= mul_prod) ? cfg.upper_limit : mul_prod;
		clamp_res = (cfg.lower_limit >= clamp_hi) ? cfg.lower_limit : clamp_hi;

		sum         = $signed({2'b00, mag_q}) + $signed({{2{corr_q[DATA_W-1]}}, corr_q});
		release_now = 1'b0;
		if (sum >= $signed({3'b000, cfg.freq_max})) begin
			out_mag = {1'b0, cfg.freq_max};
		end else if (sum <= $signed({2'b00, mag_q})) begin
			out_mag     = mag_q;
			release_now = 1'b1;
		end else begin
			out_mag = sum[DATA_W-1:0];
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE:  if (s_tvalid) state_next = ST_CHECK;
			ST_CHECK: state_next = engaged ? ST_MUL1 : ST_DONE;
			ST_MUL1:  if (mul_done) state_next = ST_ADD;
			ST_ADD:   state_next = ST_MUL2;
			ST_MUL2:  if (mul_done) state_next = ST_CLAMP;
			ST_CLAMP: state_next = ST_SUM;
			ST_SUM:   state_next = ST_DONE;
			ST_DONE:  if (!m_valid_q || m_tready) state_next = ST_IDLE;
			default:  state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		mul_start = 1'b0;
		mul_sel   = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_CHECK: mul_start = engaged;
			ST_ADD: begin
				mul_start = 1'b1;
				mul_sel   = 1'b1;
			end
			ST_DONE:  out_load = !m_valid_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			active_q  <= 1'b0;
			acc_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			case (state_q)
				ST_CHECK: begin
					active_q <= engaged;
					if (!engaged) begin
						acc_q <= '0;
					end
				end
				ST_CLAMP: acc_q <= clamp_res;
				ST_SUM:   if (release_now) active_q <= 1'b0;
				default: ;
			endcase
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && s_tvalid) begin
			cmd_q <= $signed(s_tdata[DATA_W-1:0]);
			bus_q <= s_tdata[DATA_W+UNS_W-1:DATA_W];
			inh_q <= s_tuser;
		end
		case (state_q)
			ST_CHECK: begin
				mag_q  <= mag;
				corr_q <= '0;
				freq_q <= cmd_q;
			end
			ST_CLAMP: corr_q <= clamp_res;
			ST_SUM:   freq_q <= cmd_q[DATA_W-1] ? (~out_mag + DATA_W'(1)) : out_mag;
			default: ;
		endcase
		if (out_load) begin
			m_freq_q <= freq_q;
			m_corr_q <= corr_q;
			m_act_q  <= active_q;
		end
	end

	assign s_tready = in_ready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {m_corr_q, m_freq_q};
	assign m_tuser  = m_act_q;

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the overvoltage stall PI block. A directed table
// covers reset behavior, the extreme field values and register settings,
// crossed limits, accumulator wrap and release. Random phases follow, each
// with fresh register settings and runs of bus voltages near the threshold.
// An item-level model in the bench predicts every result that the table
// does not give. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;
	import ovs_pkg::*;

	localparam int RAND_PHASES     = 14;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int HOLD_CYCLES     = 400;
	localparam int QUIET_LIMIT     = 5000;
	localparam int END_DRAIN       = 100;
	localparam int MAX_REPORTS     = 40;

	typedef struct packed {
		logic signed [DATA_W-1:0] freq_out;
		logic                     stall;
		logic signed [DATA_W-1:0] corr;
	} stall_res_t;

	typedef struct packed {
		logic                     is_cfg;
		logic [IDX_W-1:0]         idx;
		logic [DATA_W-1:0]        val;
		logic signed [DATA_W-1:0] cmd;
		logic [UNS_W-1:0]         bus;
		logic                     inh;
		logic                     typed;
		stall_res_t               known;
	} dir_row_t;

	typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [IDX_W-1:0]    cfg_index = '0;
	logic [DATA_W-1:0]   cfg_data = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [63:0]         s_tdata = '0;
	logic                s_tuser = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [63:0]         m_tdata;
	logic                m_tuser;

	cfg_t                model_cfg;
	logic                model_engaged;
	logic signed [DATA_W-1:0] model_acc;

	stall_res_t          expected_q[$];
	dir_row_t            dir_tab[$];

	int n_items = 0, n_directed = 0, n_results = 0, n_engaged = 0;
	int n_release = 0, n_capped = 0, n_settings = 0, n_err = 0;
	int burst_left = 0, quiet_cycles = 0;
	int hold_reqs = 0, hold_taken = 0, hold_left = 0, mode_left = 0;
	rx_mode_t rx_mode = RX_OPEN;

	overvoltage_stall_pi dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic signed [DATA_W-1:0] q_mul(input longint a, input longint b);
		longint p;
		p = a * b;
		return DATA_W'(p >>> Q_FRAC_BITS);
	endfunction

	function automatic stall_res_t step_model(input logic signed [DATA_W-1:0] cmd,
			input logic [UNS_W-1:0] bus, input logic inh);
		stall_res_t r;
		longint c, err, mag, total;
		logic signed [DATA_W-1:0] a;
		r.freq_out = cmd;
		r.corr = '0;
		if (!inh && (bus >= model_cfg.volt_threshold || model_engaged)) begin
			c = cmd;
			err = longint'(bus) - longint'(model_cfg.volt_threshold);
			mag = (c < 0) ? -c : c;
			model_engaged = 1'b1;
			a = model_acc + q_mul(err, longint'(model_cfg.ts_over_ti));
			a = q_mul(longint'(a), longint'($signed(model_cfg.prop_gain)));
			if ($signed(model_cfg.upper_limit) <= a) a = model_cfg.upper_limit;
			if ($signed(model_cfg.lower_limit) >= a) a = model_cfg.lower_limit;
			model_acc = a;
			r.corr = a;
			total = mag + longint'(a);
			if (total >= longint'(model_cfg.freq_max)) begin
				total = longint'(model_cfg.freq_max);
				n_capped++;
			end else if (total <= mag) begin
				total = mag;
				model_engaged = 1'b0;
				n_release++;
			end
			r.freq_out = DATA_W'((c < 0) ? -total : total);
		end else begin
			model_engaged = 1'b0;
			model_acc = '0;
		end
		r.stall = model_engaged;
		return r;
	endfunction

	function automatic dir_row_t cfg_row(input logic [IDX_W-1:0] idx,
			input logic [DATA_W-1:0] val);
		dir_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.val = val;
		return r;
	endfunction

	function automatic dir_row_t item_row(input logic signed [DATA_W-1:0] cmd,
			input logic [UNS_W-1:0] bus, input logic inh);
		dir_row_t r;
		r = '0;
		r.cmd = cmd;
		r.bus = bus;
		r.inh = inh;
		return r;
	endfunction

	function automatic dir_row_t known_row(input logic signed [DATA_W-1:0] cmd,
			input logic [UNS_W-1:0] bus, input logic inh,
			input logic signed [DATA_W-1:0] f_out, input logic stall,
			input logic signed [DATA_W-1:0] corr);
		dir_row_t r;
		r = item_row(cmd, bus, inh);
		r.typed = 1'b1;
		r.known.freq_out = f_out;
		r.known.stall = stall;
		r.known.corr = corr;
		return r;
	endfunction

	// The write enable is left high; the caller lowers it after the last write.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_VOLT_THRESHOLD: model_cfg.volt_threshold = val[UNS_W-1:0];
			REG_TS_OVER_TI:     model_cfg.ts_over_ti = val[UNS_W-1:0];
			REG_PROP_GAIN:      model_cfg.prop_gain = val;
			REG_UPPER_LIMIT:    model_cfg.upper_limit = val;
			REG_LOWER_LIMIT:    model_cfg.lower_limit = val;
			REG_FREQ_MAX:       model_cfg.freq_max = val[UNS_W-1:0];
			default: ;
		endcase
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		n_settings++;
	endtask

	task automatic offer(input dir_row_t r);
		stall_res_t res;
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
				: $urandom_range(1, 16);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, r.bus, r.cmd};
		s_tuser <= r.inh;
		do @(posedge clk); while (!s_tready);
		res = step_model(r.cmd, r.bus, r.inh);
		expected_q.push_back(r.typed ? r.known : res);
		n_items++;
	endtask

	task automatic program_phase(input int ph);
		logic [DATA_W-1:0] thr, ts, gain, up, lo, fmax;
		case (ph)
			0: begin
				thr = 32'h7FFF_FFFF; ts = 32'h7FFF_FFFF; gain = 32'h7FFF_FFFF;
				up = 32'h7FFF_FFFF; lo = 32'h8000_0000; fmax = 32'h7FFF_FFFF;
			end
			1: begin
				thr = '0; ts = '0; gain = 32'h8000_0000;
				up = 32'h8000_0000; lo = 32'h8000_0000; fmax = '0;
			end
			default: begin
				case ($urandom_range(0, 5))
					0: thr = '0;
					1: thr = 32'h7FFF_FFFF;
					default: thr = $urandom >> 1;
				endcase
				case ($urandom_range(0, 5))
					0: ts = '0;
					1: ts = 32'h7FFF_FFFF;
					2: ts = $urandom >> 1;
					default: ts = $urandom_range(1, 1 << 18);
				endcase
				case ($urandom_range(0, 7))
					0: gain = 32'h8000_0000;
					1: gain = 32'h7FFF_FFFF;
					2: gain = '0;
					3: gain = -$urandom_range(1 << 15, 1 << 18);
					4: gain = PROP_GAIN_RESET;
					default: gain = $urandom_range(1 << 15, 1 << 18);
				endcase
				case ($urandom_range(0, 5))
					0: begin
						up = -$urandom_range(0, 1 << 24);
						lo = $urandom_range(0, 1 << 24);
					end
					1: begin
						up = 32'h7FFF_FFFF;
						lo = 32'h8000_0000;
					end
					2: begin
						up = $urandom;
						lo = $urandom;
					end
					default: begin
						up = $urandom_range(0, 1 << 28);
						lo = -$urandom_range(0, 1 << 28);
					end
				endcase
				case ($urandom_range(0, 5))
					0: fmax = '0;
					1: fmax = 32'h7FFF_FFFF;
					default: fmax = $urandom >> 1;
				endcase
			end
		endcase
		write_reg(REG_VOLT_THRESHOLD, thr);
		write_reg(REG_TS_OVER_TI, ts);
		write_reg(REG_PROP_GAIN, gain);
		write_reg(REG_UPPER_LIMIT, up);
		write_reg(REG_LOWER_LIMIT, lo);
		write_reg(REG_FREQ_MAX, fmax);
		cfg_we <= 1'b0;
	endtask

	initial begin
		dir_row_t row;
		int left, run, drift, k;
		logic noisy;
		longint span, b;
		logic signed [DATA_W-1:0] cmd;

		model_cfg = '0;
		model_cfg.prop_gain = PROP_GAIN_RESET;
		model_engaged = 1'b0;
		model_acc = '0;

		// With the reset settings the threshold and the frequency cap are both
		// zero, so any item that is not inhibited engages and is capped to zero.
		dir_tab.push_back(known_row(32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1,
			32'h7FFF_FFFF, 1'b0, '0));
		dir_tab.push_back(known_row(32'h8000_0000, '0, 1'b1, 32'h8000_0000, 1'b0, '0));
		dir_tab.push_back(known_row(32'h8000_0000, '0, 1'b0, '0, 1'b1, '0));
		dir_tab.push_back(known_row(32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0, '0, 1'b1, '0));
		dir_tab.push_back(known_row(32'h0000_0001, '0, 1'b1, 32'h0000_0001, 1'b0, '0));
		dir_tab.push_back(cfg_row(REG_VOLT_THRESHOLD, 32'h0140_0000));
		dir_tab.push_back(cfg_row(REG_TS_OVER_TI, 32'h0000_4000));
		dir_tab.push_back(cfg_row(REG_UPPER_LIMIT, 32'h0100_0000));
		dir_tab.push_back(cfg_row(REG_LOWER_LIMIT, 32'hFF00_0000));
		dir_tab.push_back(cfg_row(REG_FREQ_MAX, 32'h7FFF_FFFF));
		dir_tab.push_back(known_row(32'h0020_0000, '0, 1'b0, 32'h0020_0000, 1'b0, '0));
		dir_tab.push_back(item_row(32'h0020_0000, 31'h0180_0000, 1'b0));
		dir_tab.push_back(item_row(32'hFFE0_0000, 31'h0140_0000, 1'b0));
		dir_tab.push_back(item_row(32'h0020_0000, 31'h0100_0000, 1'b0));
		dir_tab.push_back(item_row(32'h0020_0000, '0, 1'b0));
		dir_tab.push_back(item_row(32'h0020_0000, 31'h0180_0000, 1'b1));
		// Crossed limits: the lower limit wins, and the most negative command
		// overflows the cap.
		dir_tab.push_back(cfg_row(REG_UPPER_LIMIT, 32'hFFFF_FFF0));
		dir_tab.push_back(cfg_row(REG_LOWER_LIMIT, 32'h0000_0010));
		dir_tab.push_back(known_row(32'h8000_0000, 31'h0140_0000, 1'b0,
			32'h8000_0001, 1'b1, 32'h0000_0010));
		dir_tab.push_back(item_row(32'h0000_0100, 31'h0140_0000, 1'b0));
		// Full-scale error and gain make the accumulator and the multiply wrap.
		dir_tab.push_back(cfg_row(REG_VOLT_THRESHOLD, '0));
		dir_tab.push_back(cfg_row(REG_TS_OVER_TI, 32'h7FFF_FFFF));
		dir_tab.push_back(cfg_row(REG_PROP_GAIN, 32'h8000_0000));
		dir_tab.push_back(cfg_row(REG_UPPER_LIMIT, 32'h7FFF_FFFF));
		dir_tab.push_back(cfg_row(REG_LOWER_LIMIT, 32'h8000_0000));
		dir_tab.push_back(cfg_row(REG_FREQ_MAX, 32'h4000_0000));
		dir_tab.push_back(item_row('0, 31'h7FFF_FFFF, 1'b0));
		dir_tab.push_back(item_row('0, 31'h7FFF_FFFF, 1'b0));
		dir_tab.push_back(item_row(32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b0));
		dir_tab.push_back(item_row(32'h7FFF_0000, 31'h0000_1000, 1'b0));
		dir_tab.push_back(cfg_row(REG_PROP_GAIN, PROP_GAIN_RESET));
		dir_tab.push_back(cfg_row(REG_TS_OVER_TI, '0));
		dir_tab.push_back(item_row(32'h1234_5678, 31'h7FFF_FFFF, 1'b0));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			row = dir_tab[i];
			if (row.is_cfg) begin
				if (i == 0 || !dir_tab[i-1].is_cfg) settle();
				write_reg(row.idx, row.val);
			end else begin
				if (cfg_we) cfg_we <= 1'b0;
				offer(row);
				n_directed++;
			end
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			settle();
			program_phase(ph);
			if (ph == 2) hold_reqs++;
			left = ITEMS_PER_PHASE;
			while (left > 0) begin
				noisy = ($urandom_range(0, 9) >= 8);
				run = noisy ? $urandom_range(1, 6) : $urandom_range(4, 30);
				span = longint'(1) << $urandom_range(4, 24);
				drift = $urandom_range(0, 2);
				for (k = 0; k < run && left > 0; k++) begin
					case ($urandom_range(0, 7))
						0: cmd = 32'h8000_0000;
						1: cmd = 32'h7FFF_FFFF;
						2: cmd = $urandom_range(0, 1 << 20);
						3: cmd = -$urandom_range(0, 1 << 20);
						default: cmd = $urandom;
					endcase
					if (noisy) begin
						row = item_row(cmd, UNS_W'($urandom), 1'($urandom_range(0, 1)));
					end else begin
						// Bus voltage wanders around the threshold, offset up, level
						// or down for the whole run.
						b = longint'(model_cfg.volt_threshold)
							+ longint'($urandom_range(0, 32'(2 * span))) - span
							+ (longint'(drift) - 1) * (span / 2);
						if (b < 0) b = 0;
						if (b > longint'(32'h7FFF_FFFF)) b = longint'(32'h7FFF_FFFF);
						row = item_row(cmd, UNS_W'(b), $urandom_range(0, 19) == 0);
					end
					offer(row);
					left--;
				end
			end
		end

		settle();
		repeat (END_DRAIN) @(posedge clk);
		$display("Covered %0d items (%0d from the directed table) over %0d register settings.",
			n_items, n_directed, n_settings);
		$display("Checked %0d results: %0d engaged, %0d releases, %0d capped at the limit.",
			n_results, n_engaged, n_release, n_capped);
		if (n_err == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_taken != hold_reqs) begin
			hold_taken = hold_taken + 1;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(32, 512);
			end
			mode_left = mode_left - 1;
			case (rx_mode)
				RX_OPEN:   m_tready <= 1'b1;
				RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
				default:   m_tready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		stall_res_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				n_results++;
				if (m_tuser) n_engaged++;
				if (expected_q.size() == 0) begin
					n_err++;
					if (n_err <= MAX_REPORTS)
						$display("%0t: unexpected item: freq_out %h stall %b correction %h",
							$time, m_tdata[31:0], m_tuser, m_tdata[63:32]);
				end else begin
					want = expected_q.pop_front();
					if (m_tdata[31:0] !== want.freq_out) begin
						n_err++;
						if (n_err <= MAX_REPORTS)
							$display("%0t: freq_out expected %h actual %h",
								$time, want.freq_out, m_tdata[31:0]);
					end
					if (m_tuser !== want.stall) begin
						n_err++;
						if (n_err <= MAX_REPORTS)
							$display("%0t: stall_active expected %b actual %b",
								$time, want.stall, m_tuser);
					end
					if (m_tdata[63:32] !== want.corr) begin
						n_err++;
						if (n_err <= MAX_REPORTS)
							$display("%0t: correction expected %h actual %h",
								$time, want.corr, m_tdata[63:32]);
					end
				end
			end
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
				quiet_cycles = 0;
			else
				quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

endmodule
